FILE: rtl/lsl_pkg.sv
`default_nettype none

package lsl_pkg;

    // field widths
    localparam int COUNT_W = 16;
    localparam int LUX_W   = 17;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATION_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_GAIN        = 2'd1;

    // integration mode codes (the remaining code 3 also means 402 ms)
    localparam logic [1:0] MODE_13MS  = 2'd0;
    localparam logic [1:0] MODE_101MS = 2'd1;
    localparam logic [1:0] MODE_402MS = 2'd2;
    localparam logic [1:0] MODE_RESET = MODE_101MS;

    // clip thresholds per integration time
    localparam logic [COUNT_W-1:0] CLIP_13MS  = 16'd4900;
    localparam logic [COUNT_W-1:0] CLIP_101MS = 16'd37000;
    localparam logic [COUNT_W-1:0] CLIP_402MS = 16'd65000;

    // channel scale, 2^10 fixed point, before the unity gain boost
    localparam int CH_SHIFT   = 10;
    localparam int SCALE_W    = 15;
    localparam int SCALE_EXT_W = SCALE_W + 4;
    localparam logic [SCALE_W-1:0] SCALE_13MS  = 15'h7517;
    localparam logic [SCALE_W-1:0] SCALE_101MS = 15'h0FE7;
    localparam logic [SCALE_W-1:0] SCALE_402MS = 15'h0400;

    // scaled channel and divider widths
    localparam int CH_W    = 22;
    localparam int QUO_W   = 11;
    localparam int REM_W   = CH_W + QUO_W;
    localparam int RATIO_W = QUO_W;
    localparam int LUX_SHIFT = 14;
    localparam int COEF_W  = 10;
    localparam int PROD_W  = CH_W + COEF_W;

    // saturated lux value
    localparam logic [LUX_W-1:0] LUX_CLIPPED = 17'd65536;

    // piecewise-linear segments
    localparam int NUM_SEG = 8;
    localparam int SEG_W   = 3;
    localparam logic [COEF_W-1:0] SEG_KNEE [NUM_SEG-1] = '{
        10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a
    };
    localparam logic [COEF_W-1:0] SEG_B [NUM_SEG] = '{
        10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
    };
    localparam logic [COEF_W-1:0] SEG_M [NUM_SEG] = '{
        10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
    };

    // payload carried down the pipeline
    typedef struct packed {
        logic [COUNT_W-1:0]     bb;
        logic [COUNT_W-1:0]     ir;
        logic [SCALE_EXT_W-1:0] scale;
        logic                   sat;
        logic [CH_W-1:0]        c0;
        logic [CH_W-1:0]        c1;
        logic                   over;
        logic                   zero;
        logic [REM_W-1:0]       rem;
        logic [QUO_W-1:0]       quo;
        logic [SEG_W-1:0]       seg;
        logic [PROD_W-1:0]      pos;
        logic [PROD_W-1:0]      neg;
        logic [LUX_W-1:0]       lux;
    } pipe_t;

    // first segment whose knee is not below the ratio, the last one when none is or when over is set
    function automatic logic [SEG_W-1:0] seg_select(input logic [RATIO_W-1:0] ratio,
                                                    input logic over);
        logic [SEG_W-1:0] seg;
        seg = SEG_W'(NUM_SEG - 1);
        for (int i = NUM_SEG - 2; i >= 0; i--) begin
            if ({1'b0, ratio} <= {2'b00, SEG_KNEE[i]}) begin
                seg = SEG_W'(i);
            end
        end
        if (over) begin
            seg = SEG_W'(NUM_SEG - 1);
        end
        return seg;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lsl_sample_if.sv
`default_nettype none

interface lsl_sample_if
    import lsl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] broadband;
    logic [COUNT_W-1:0] infrared;

    modport source (output valid, output broadband, output infrared, input ready);
    modport sink   (input valid, input broadband, input infrared, output ready);
endinterface

`default_nettype wire

FILE: rtl/lsl_result_if.sv
`default_nettype none

interface lsl_result_if
    import lsl_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LUX_W-1:0] lux;
    logic             saturated;

    modport source (output valid, output lux, output saturated, input ready);
    modport sink   (input valid, input lux, input saturated, output ready);
endinterface

`default_nettype wire

FILE: rtl/light_sensor_lux_calc_unit.sv
// a sample transfer loads the entry stage; its result is offered from the output stage
// throughput: one sample pair per cycle while the output is not stalled; the ratio divider is 11 restoring
// stages, one quotient bit each, and every stage holds its own item
// a stalled output only blocks the input once every stage is full
// reset (rst_n low, asynchronous) empties the pipeline and sets 101 ms, unity gain
`default_nettype none

module light_sensor_lux_calc_unit
    import lsl_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_wdata,
    lsl_sample_if.sink           sample,
    lsl_result_if.source         result
);

    localparam int ST_SCALE   = 1;
    localparam int ST_DIVINIT = 2;
    localparam int DIV_FIRST  = 3;
    localparam int ST_SEG     = DIV_FIRST + QUO_W;
    localparam int ST_MUL     = ST_SEG + 1;
    localparam int ST_OUT     = ST_MUL + 1;
    localparam int NUM_STAGES = ST_OUT + 1;
    localparam int SPROD_W    = COUNT_W + SCALE_EXT_W;

    logic [1:0] integration_mode_reg;
    logic       high_gain_reg;

    pipe_t stage_reg  [NUM_STAGES];
    pipe_t stage_next [NUM_STAGES];
    logic  valid_reg  [NUM_STAGES];
    logic  advance    [NUM_STAGES];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integration_mode_reg <= MODE_RESET;
            high_gain_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INTEGRATION_MODE: integration_mode_reg <= cfg_wdata[1:0];
                CFG_HIGH_GAIN:        high_gain_reg        <= cfg_wdata[0];
                default:              ;
            endcase
        end
    end

    // per-stage advance: a stage loads when it is empty or its successor moves
    assign advance[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || result.ready;
    for (genvar i = 0; i < NUM_STAGES - 1; i++)
    begin : g_adv
        assign advance[i] = !valid_reg[i] || advance[i+1];
    end

    assign sample.ready = advance[0];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (advance[0])
            begin
                valid_reg[0] <= sample.valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (advance[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // payload registers
    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_pay
        always_ff @(posedge clk)
        begin
            if (advance[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    // entry: clip check and scale selection
    logic [COUNT_W-1:0] clip;
    logic [SCALE_W-1:0] scale_base;

    always_comb
    begin
        unique case (integration_mode_reg)
            MODE_13MS:
            begin
                clip       = CLIP_13MS;
                scale_base = SCALE_13MS;
            end
            MODE_101MS:
            begin
                clip       = CLIP_101MS;
                scale_base = SCALE_101MS;
            end
            default:
            begin
                clip       = CLIP_402MS;
                scale_base = SCALE_402MS;
            end
        endcase

        stage_next[0]       = '0;
        stage_next[0].bb    = sample.broadband;
        stage_next[0].ir    = sample.infrared;
        stage_next[0].sat   = (sample.broadband > clip) || (sample.infrared > clip);
        stage_next[0].scale = high_gain_reg ? {4'b0000, scale_base} : {scale_base, 4'b0000};
    end

    // scale both channels, 2^10 fixed point truncated
    logic [SPROD_W-1:0] prod_bb;
    logic [SPROD_W-1:0] prod_ir;

    always_comb
    begin
        prod_bb = SPROD_W'(stage_reg[ST_SCALE-1].bb) * SPROD_W'(stage_reg[ST_SCALE-1].scale);
        prod_ir = SPROD_W'(stage_reg[ST_SCALE-1].ir) * SPROD_W'(stage_reg[ST_SCALE-1].scale);
        stage_next[ST_SCALE]    = stage_reg[ST_SCALE-1];
        stage_next[ST_SCALE].c0 = prod_bb[CH_SHIFT +: CH_W];
        stage_next[ST_SCALE].c1 = prod_ir[CH_SHIFT +: CH_W];
    end

    // divider setup; quotients of 2048 or more all land in the last segment
    always_comb
    begin
        stage_next[ST_DIVINIT]      = stage_reg[ST_DIVINIT-1];
        stage_next[ST_DIVINIT].over = {1'b0, stage_reg[ST_DIVINIT-1].c1}
                                      >= {stage_reg[ST_DIVINIT-1].c0, 1'b0};
        stage_next[ST_DIVINIT].zero = (stage_reg[ST_DIVINIT-1].c0 == '0);
        stage_next[ST_DIVINIT].rem  = {1'b0, stage_reg[ST_DIVINIT-1].c1, 10'b0};
        stage_next[ST_DIVINIT].quo  = '0;
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        localparam int K = QUO_W - 1 - j;
        logic [REM_W-1:0] trial;

        always_comb
        begin
            trial = {{QUO_W{1'b0}}, stage_reg[DIV_FIRST+j-1].c0} << K;
            stage_next[DIV_FIRST+j] = stage_reg[DIV_FIRST+j-1];
            if (stage_reg[DIV_FIRST+j-1].rem >= trial)
            begin
                stage_next[DIV_FIRST+j].rem    = stage_reg[DIV_FIRST+j-1].rem - trial;
                stage_next[DIV_FIRST+j].quo[K] = 1'b1;
            end
        end
    end

    // rounded ratio and segment lookup
    logic [QUO_W:0]      quo_inc;
    logic [RATIO_W-1:0]  ratio;

    always_comb
    begin
        quo_inc = {1'b0, stage_reg[ST_SEG-1].quo} + {{QUO_W{1'b0}}, 1'b1};
        ratio   = stage_reg[ST_SEG-1].zero ? '0 : quo_inc[QUO_W:1];
        stage_next[ST_SEG]     = stage_reg[ST_SEG-1];
        stage_next[ST_SEG].seg = seg_select(ratio,
                                            stage_reg[ST_SEG-1].over && !stage_reg[ST_SEG-1].zero);
    end

    // offset and slope products
    always_comb
    begin
        stage_next[ST_MUL]     = stage_reg[ST_MUL-1];
        stage_next[ST_MUL].pos = PROD_W'(stage_reg[ST_MUL-1].c0)
                                 * PROD_W'(SEG_B[stage_reg[ST_MUL-1].seg]);
        stage_next[ST_MUL].neg = PROD_W'(stage_reg[ST_MUL-1].c1)
                                 * PROD_W'(SEG_M[stage_reg[ST_MUL-1].seg]);
    end

    // clamp at zero, round, drop the fraction; a clipped sample gets the saturated lux value
    logic [PROD_W:0] acc;

    always_comb
    begin
        if (stage_reg[ST_OUT-1].pos > stage_reg[ST_OUT-1].neg)
        begin
            acc = {1'b0, stage_reg[ST_OUT-1].pos - stage_reg[ST_OUT-1].neg};
        end
        else
        begin
            acc = '0;
        end
        acc = acc + (PROD_W+1)'(1 << (LUX_SHIFT - 1));
        stage_next[ST_OUT]     = stage_reg[ST_OUT-1];
        stage_next[ST_OUT].lux = stage_reg[ST_OUT-1].sat ? LUX_CLIPPED
                                                         : acc[LUX_SHIFT +: LUX_W];
    end

    // result channel
    assign result.valid     = valid_reg[NUM_STAGES-1];
    assign result.lux       = stage_reg[NUM_STAGES-1].lux;
    assign result.saturated = stage_reg[NUM_STAGES-1].sat;

endmodule

`default_nettype wire

FILE: rtl/lsl_checker.sv
`default_nettype none

module lsl_checker
    import lsl_pkg::*;
(
    input wire             clk,
    input wire             rst_n,
    input wire             r_valid,
    input wire             r_ready,
    input wire [LUX_W-1:0] r_lux,
    input wire             r_saturated
);

    // nothing is offered in the cycle after reset is seen
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !r_valid)
        else $error("result valid during reset");

    // a clipped sample always reports the clipped lux value
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && r_saturated) |-> (r_lux == LUX_CLIPPED))
        else $error("saturated result with wrong lux");

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && !r_ready) |=> r_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && !r_ready) |=> ($stable(r_lux) && $stable(r_saturated)))
        else $error("result payload changed while stalled");

endmodule

bind light_sensor_lux_calc_unit lsl_checker u_lsl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .r_valid     (result.valid),
    .r_ready     (result.ready),
    .r_lux       (result.lux),
    .r_saturated (result.saturated)
);

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

module tb
    import lsl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int PIPE_LATENCY  = 17;
    localparam int STALL_LIMIT   = 2000;
    localparam int CFG_NUM_REGS  = 2;
    localparam int NUM_SETTINGS  = 8;
    localparam int ITEMS_PER_SET = 60;
    localparam int MAX_REPORTS   = 10;

    // the fourth mode code behaves as the 402 ms code
    localparam logic [1:0] MODE_402MS_ALT = 2'd3;

    // segment knees, offsets and slopes of the lux curve
    localparam logic [9:0] KNEE_TBL [7] = '{
        10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a
    };
    localparam logic [9:0] OFFSET_TBL [8] = '{
        10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
    };
    localparam logic [9:0] SLOPE_TBL [8] = '{
        10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
    };

    // settings swept by the random part
    localparam logic [1:0] SWEEP_MODE [NUM_SETTINGS] = '{
        MODE_13MS, MODE_101MS, MODE_402MS, MODE_402MS_ALT,
        MODE_13MS, MODE_101MS, MODE_402MS_ALT, MODE_402MS
    };
    localparam logic SWEEP_GAIN [NUM_SETTINGS] = '{
        1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1
    };

    typedef struct {
        logic [LUX_W-1:0] lux;
        logic             saturated;
    } lux_result_t;

    // lux predictor with its own copy of the registers
    class lux_scoreboard;
        logic [1:0]  mode_r;
        logic        high_gain_r;
        lux_result_t lux_q[$];
        int          errors;

        function new();
            mode_r      = MODE_RESET;
            high_gain_r = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_INTEGRATION_MODE)
            begin
                mode_r = data[1:0];
            end
            else if (idx == CFG_HIGH_GAIN)
            begin
                high_gain_r = data[0];
            end
        endfunction

        function int unsigned clip_level();
            case (mode_r)
                MODE_13MS:  return 4900;
                MODE_101MS: return 37000;
                default:    return 65000;
            endcase
        endfunction

        function lux_result_t compute_lux(input logic [COUNT_W-1:0] bb,
                                          input logic [COUNT_W-1:0] ir);
            lux_result_t r;
            logic [63:0] scale, c0, c1, ratio, pos, neg, acc;
            int          seg;
            case (mode_r)
                MODE_13MS:  scale = 64'h7517;
                MODE_101MS: scale = 64'h0FE7;
                default:    scale = 64'h0400;
            endcase
            if (bb > clip_level() || ir > clip_level())
            begin
                r.lux       = LUX_W'(65536);
                r.saturated = 1'b1;
                return r;
            end
            // unity gain is boosted by sixteen
            if (!high_gain_r)
            begin
                scale = scale << 4;
            end
            c0 = (64'(bb) * scale) >> 10;
            c1 = (64'(ir) * scale) >> 10;
            // rounded ir/broadband ratio, zero when broadband scales to zero
            ratio = (c0 != 0) ? ((c1 << 10) / c0) : 64'd0;
            ratio = (ratio + 1) >> 1;
            seg = 7;
            for (int i = 6; i >= 0; i--)
            begin
                if (ratio <= 64'(KNEE_TBL[i]))
                begin
                    seg = i;
                end
            end
            pos = c0 * 64'(OFFSET_TBL[seg]);
            neg = c1 * 64'(SLOPE_TBL[seg]);
            acc = (pos > neg) ? (pos - neg) : 64'd0;
            acc = acc + (64'd1 << 13);
            r.lux       = LUX_W'(acc >> 14);
            r.saturated = 1'b0;
            return r;
        endfunction

        function void note_sample(input logic [COUNT_W-1:0] bb,
                                  input logic [COUNT_W-1:0] ir);
            lux_q.push_back(compute_lux(bb, ir));
        endfunction

        function void flag_error(input string msg);
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $display("%s", msg);
            end
        endfunction

        function void check_result(input logic [LUX_W-1:0] lux, input logic sat);
            lux_result_t want;
            if (lux_q.size() == 0)
            begin
                flag_error($sformatf("unexpected result lux=%0d sat=%0b", lux, sat));
                return;
            end
            want = lux_q.pop_front();
            if (lux !== want.lux || sat !== want.saturated)
            begin
                flag_error($sformatf("result mismatch: expected lux=%0d sat=%0b, got lux=%0d sat=%0b",
                                     want.lux, want.saturated, lux, sat));
            end
        endfunction

        function int pending();
            return lux_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    src_idle_pct;
    int                    dst_idle_pct;
    int                    stall_cycles;
    lux_scoreboard         sb = new();

    lsl_sample_if sample_ch ();
    lsl_result_if result_ch ();

    light_sensor_lux_calc_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // transfer monitor and stall counter
    always @(posedge clk)
    begin
        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            sb.note_sample(sample_ch.broadband, sample_ch.infrared);
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            sb.check_result(result_ch.lux, result_ch.saturated);
        end
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // watchdog
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // register write, the caller lowers the enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(input logic [1:0] mode, input logic gain);
        logic [CFG_DATA_W-1:0] gain_data;
        gain_data    = CFG_DATA_W'($urandom);
        gain_data[0] = gain;
        write_reg(CFG_INTEGRATION_MODE, mode);
        write_reg(CFG_HIGH_GAIN, gain_data);
        // a write to an unused index must change nothing
        write_reg(CFG_IDX_W'($urandom_range(CFG_NUM_REGS, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // one sample transfer with random gaps before it
    task automatic send_sample(input logic [COUNT_W-1:0] bb, input logic [COUNT_W-1:0] ir);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.broadband <= bb;
        sample_ch.infrared  <= ir;
        @(posedge clk);
        while (!sample_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // hold off until every expected result has come back
    task automatic wait_drain();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic send_random();
        int unsigned    clip;
        int unsigned    kind;
        logic [63:0]    tmp;
        logic [COUNT_W-1:0] bb, ir, t;
        clip = sb.clip_level();
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            // in range, ratio spread over every segment
            bb  = COUNT_W'($urandom_range(0, clip));
            tmp = (64'(bb) * $urandom_range(0, 1400)) / 1000;
            ir  = (tmp > clip) ? COUNT_W'(clip) : COUNT_W'(tmp);
        end
        else if (kind < 60)
        begin
            bb = COUNT_W'($urandom_range(0, 255));
            ir = COUNT_W'($urandom_range(0, 255));
        end
        else if (kind < 75)
        begin
            // around the clip threshold
            bb = COUNT_W'(clip - 2 + $urandom_range(0, 4));
            ir = COUNT_W'($urandom_range(0, clip));
            if ($urandom_range(0, 1))
            begin
                t  = bb;
                bb = ir;
                ir = t;
            end
        end
        else
        begin
            bb = COUNT_W'($urandom);
            ir = COUNT_W'($urandom);
        end
        send_sample(bb, ir);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_INTEGRATION_MODE;
        cfg_wdata           = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.broadband = '0;
        sample_ch.infrared  = '0;
        result_ch.ready     = 1'b0;
        stall_cycles        = 0;
        src_idle_pct        = 22;
        dst_idle_pct        = 61;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset setting, extremes, clip edge, every segment
        send_sample(16'd0, 16'd0);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'd37000, 16'd37000);
        send_sample(16'd37001, 16'd0);
        send_sample(16'd0, 16'd37001);
        send_sample(16'd0, 16'd500);
        send_sample(16'd1000, 16'd100);
        send_sample(16'd512, 16'd64);
        send_sample(16'd512, 16'd65);
        send_sample(16'd1000, 16'd200);
        send_sample(16'd1000, 16'd300);
        send_sample(16'd1000, 16'd450);
        send_sample(16'd1000, 16'd550);
        send_sample(16'd1000, 16'd700);
        send_sample(16'd1000, 16'd1200);
        send_sample(16'd1000, 16'd1400);
        send_sample(16'd1000, 16'd1000);
        wait_drain();
        apply_setting(MODE_13MS, 1'b1);
        send_sample(16'd4900, 16'd4900);
        send_sample(16'd4901, 16'd0);
        send_sample(16'd1, 16'd4900);
        send_sample(16'd65535, 16'd0);
        wait_drain();
        apply_setting(MODE_402MS_ALT, 1'b1);
        send_sample(16'd65000, 16'd65000);
        send_sample(16'd65001, 16'd0);
        send_sample(16'd1, 16'd0);
        wait_drain();

        // random: settings sweep under three idling profiles
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            if (s < 3)
            begin
                src_idle_pct = 22;
                dst_idle_pct = 61;
            end
            else if (s < 6)
            begin
                src_idle_pct = 61;
                dst_idle_pct = 22;
            end
            else
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            apply_setting(SWEEP_MODE[s], SWEEP_GAIN[s]);
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                send_random();
                if ($urandom_range(0, 49) == 0)
                begin
                    wait_drain();
                end
            end
            wait_drain();
        end

        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/lsl_pkg.sv
rtl/lsl_sample_if.sv
rtl/lsl_result_if.sv
rtl/light_sensor_lux_calc_unit.sv
rtl/lsl_checker.sv
sim/tb.sv
